// ----- design/v4a_pkg.sv -----
// Package for the four-component Q16.16 vector unit.
// Holds the widths, operation codes, item structs and the saturation helpers.
// No dependencies.
package v4a_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int OPW       = 4;
    localparam int PW        = 2 * DW;
    localparam int SUMW      = PW + 2;
    localparam int RADW      = SUMW;
    localparam int ROOTW     = RADW / 2;
    localparam int REMW      = ROOTW + 3;
    localparam int NUMW      = DW + FRAC_BITS;
    localparam int DENW      = ROOTW;

    typedef logic [OPW-1:0] op_t;

    localparam op_t OP_ADD   = 4'd0;
    localparam op_t OP_SUB   = 4'd1;
    localparam op_t OP_NEG   = 4'd2;
    localparam op_t OP_SCALE = 4'd3;
    localparam op_t OP_DIV   = 4'd4;
    localparam op_t OP_DOT   = 4'd5;
    localparam op_t OP_CROSS = 4'd6;
    localparam op_t OP_MAG   = 4'd7;
    localparam op_t OP_NORM  = 4'd8;

    localparam logic signed [SUMW-1:0] RND_HALF = SUMW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUMW-1:0] ONE_PRE  = SUMW'(1) << (2 * FRAC_BITS);
    localparam logic signed [SUMW-1:0] SAT_HI   = (SUMW'(1) << (DW - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] SAT_LO   = -(SUMW'(1) << (DW - 1));

    typedef struct packed {
        op_t                   operation;
        logic signed [DW-1:0]  a_x;
        logic signed [DW-1:0]  a_y;
        logic signed [DW-1:0]  a_z;
        logic signed [DW-1:0]  a_w;
        logic signed [DW-1:0]  b_x;
        logic signed [DW-1:0]  b_y;
        logic signed [DW-1:0]  b_z;
        logic signed [DW-1:0]  b_w;
        logic signed [DW-1:0]  scalar_in;
    } in_t;

    typedef struct packed {
        logic signed [DW-1:0]  r_x;
        logic signed [DW-1:0]  r_y;
        logic signed [DW-1:0]  r_z;
        logic signed [DW-1:0]  r_w;
        logic signed [DW-1:0]  scalar_out;
        logic                  error_flag;
    } out_t;

    // Result fields and division controls that travel down the pipeline.
    typedef struct packed {
        op_t                   op;
        logic                  err;
        logic [3:0][DW-1:0]    r;
        logic [DW-1:0]         sc;
        logic [3:0]            neg;
        logic [DENW-1:0]       den;
    } res_t;

    typedef struct packed {
        res_t                  res;
        logic [3:0][NUMW-1:0]  num;
    } pre_t;

    function automatic logic signed [DW-1:0] sat_fn(input logic signed [SUMW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[DW-1:0];
        end
        else if (v < SAT_LO) begin
            return SAT_LO[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    function automatic logic signed [SUMW-1:0] sx(input logic signed [DW-1:0] v);
        return {{(SUMW-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic signed [SUMW-1:0] sxp(input logic signed [PW-1:0] v);
        return {{(SUMW-PW){v[PW-1]}}, v};
    endfunction

    function automatic logic [DW-1:0] abs_fn(input logic signed [DW-1:0] v);
        return v[DW-1] ? -v : v;
    endfunction

endpackage

// ----- design/v4a_front.sv -----
// Front pipeline of the vector unit: operand select, multiply, sums, rounding.
// Five register stages. Depends on v4a_pkg.
module v4a_front import v4a_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  in_t              in_item,
    output logic             out_vld,
    output pre_t             out_pre,
    output logic [RADW-1:0]  out_rad
);

    logic [4:0]              vld_reg;
    in_t                     s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;

    logic signed [DW-1:0]    ia [4];
    logic signed [DW-1:0]    ib [4];
    logic signed [DW-1:0]    a2 [4];
    logic signed [DW-1:0]    b2 [4];
    logic signed [DW-1:0]    a4 [4];

    logic signed [DW-1:0]    x_next [6];
    logic signed [DW-1:0]    y_next [6];
    logic signed [DW-1:0]    x_reg [6];
    logic signed [DW-1:0]    y_reg [6];
    logic signed [PW-1:0]    p_reg [6];

    logic signed [SUMW-1:0]  s01_next, s23_next, s01_reg, s23_reg;
    logic signed [SUMW-1:0]  c_next [3];
    logic signed [SUMW-1:0]  c_reg [3];
    logic signed [SUMW-1:0]  as_next [4];
    logic signed [SUMW-1:0]  as_reg [4];
    logic signed [SUMW-1:0]  ps_reg [4];

    logic signed [SUMW-1:0]  v_next [4];
    logic signed [SUMW-1:0]  v_reg [4];
    logic signed [SUMW-1:0]  vsc_next, vsc_reg;
    logic                    rnd_next, rnd_reg;

    pre_t                    pre_next, pre_reg;
    logic [RADW-1:0]         rad_reg;

    assign ia[0] = in_item.a_x;
    assign ia[1] = in_item.a_y;
    assign ia[2] = in_item.a_z;
    assign ia[3] = in_item.a_w;
    assign ib[0] = in_item.b_x;
    assign ib[1] = in_item.b_y;
    assign ib[2] = in_item.b_z;
    assign ib[3] = in_item.b_w;
    assign a2[0] = s2_item_reg.a_x;
    assign a2[1] = s2_item_reg.a_y;
    assign a2[2] = s2_item_reg.a_z;
    assign a2[3] = s2_item_reg.a_w;
    assign b2[0] = s2_item_reg.b_x;
    assign b2[1] = s2_item_reg.b_y;
    assign b2[2] = s2_item_reg.b_z;
    assign b2[3] = s2_item_reg.b_w;
    assign a4[0] = s4_item_reg.a_x;
    assign a4[1] = s4_item_reg.a_y;
    assign a4[2] = s4_item_reg.a_z;
    assign a4[3] = s4_item_reg.a_w;

    // Stage 1: steer the operand pairs onto the six multipliers.
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            x_next[i] = '0;
            y_next[i] = '0;
        end
        unique case (in_item.operation) inside
            OP_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    x_next[i] = ia[i];
                    y_next[i] = in_item.scalar_in;
                end
            end
            OP_DOT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    x_next[i] = ia[i];
                    y_next[i] = ib[i];
                end
            end
            OP_MAG, OP_NORM:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    x_next[i] = ia[i];
                    y_next[i] = ia[i];
                end
            end
            OP_CROSS:
            begin
                x_next[0] = in_item.a_y;  y_next[0] = in_item.b_z;
                x_next[1] = in_item.b_y;  y_next[1] = in_item.a_z;
                x_next[2] = in_item.a_z;  y_next[2] = in_item.b_x;
                x_next[3] = in_item.b_z;  y_next[3] = in_item.a_x;
                x_next[4] = in_item.a_x;  y_next[4] = in_item.b_y;
                x_next[5] = in_item.b_x;  y_next[5] = in_item.a_y;
            end
            default:
            begin
            end
        endcase
    end

    // Stage 3: pair sums, cross differences and the plain add paths.
    always_comb
    begin
        s01_next = sxp(p_reg[0]) + sxp(p_reg[1]);
        s23_next = sxp(p_reg[2]) + sxp(p_reg[3]);
        c_next[0] = sxp(p_reg[0]) - sxp(p_reg[1]);
        c_next[1] = sxp(p_reg[2]) - sxp(p_reg[3]);
        c_next[2] = sxp(p_reg[4]) - sxp(p_reg[5]);
        for (int i = 0; i < 4; i++)
        begin
            case (s2_item_reg.operation)
                OP_ADD:  as_next[i] = sx(a2[i]) + sx(b2[i]);
                OP_SUB:  as_next[i] = sx(a2[i]) - sx(b2[i]);
                OP_NEG:  as_next[i] = -sx(a2[i]);
                default: as_next[i] = '0;
            endcase
        end
    end

    // Stage 4: pick the pre-rounding value of each component.
    always_comb
    begin
        vsc_next = s01_reg + s23_reg;
        rnd_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            v_next[i] = '0;
        end
        case (s3_item_reg.operation) inside
            OP_ADD, OP_SUB, OP_NEG:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    v_next[i] = as_reg[i];
                end
            end
            OP_SCALE:
            begin
                rnd_next = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    v_next[i] = ps_reg[i];
                end
            end
            OP_CROSS:
            begin
                // The w component is 1.0 pre-scaled so that rounding leaves it exact.
                rnd_next  = 1'b1;
                v_next[0] = c_reg[0];
                v_next[1] = c_reg[1];
                v_next[2] = c_reg[2];
                v_next[3] = ONE_PRE;
            end
            default:
            begin
            end
        endcase
    end

    // Stage 5: round half up, saturate, and set up the divider operands.
    always_comb
    begin
        logic signed [SUMW-1:0] rv;
        logic signed [SUMW-1:0] rs;
        pre_next = '0;
        pre_next.res.op = s4_item_reg.operation;
        for (int i = 0; i < 4; i++)
        begin
            rv = (v_reg[i] + RND_HALF) >>> FRAC_BITS;
            pre_next.res.r[i] = rnd_reg ? sat_fn(rv) : sat_fn(v_reg[i]);
            pre_next.num[i] = {abs_fn(a4[i]), {FRAC_BITS{1'b0}}};
            pre_next.res.neg[i] = a4[i][DW-1]
                ^ ((s4_item_reg.operation == OP_DIV) & s4_item_reg.scalar_in[DW-1]);
        end
        rs = (vsc_reg + RND_HALF) >>> FRAC_BITS;
        if (s4_item_reg.operation == OP_DOT)
        begin
            pre_next.res.sc = sat_fn(rs);
        end
        pre_next.res.den = {{(DENW-DW){1'b0}}, abs_fn(s4_item_reg.scalar_in)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= in_item;
            s2_item_reg <= s1_item_reg;
            s3_item_reg <= s2_item_reg;
            s4_item_reg <= s3_item_reg;
            for (int i = 0; i < 6; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                p_reg[i] <= x_reg[i] * y_reg[i];
            end
            s01_reg <= s01_next;
            s23_reg <= s23_next;
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= c_next[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                as_reg[i] <= as_next[i];
                ps_reg[i] <= sxp(p_reg[i]);
                v_reg[i]  <= v_next[i];
            end
            vsc_reg <= vsc_next;
            rnd_reg <= rnd_next;
            pre_reg <= pre_next;
            rad_reg <= vsc_reg;
        end
    end

    assign out_vld = vld_reg[4];
    assign out_pre = pre_reg;
    assign out_rad = rad_reg;

endmodule

// ----- design/v4a_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Carries the item's other fields alongside. Depends on v4a_pkg.
module v4a_sqrt import v4a_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [RADW-1:0]   in_rad,
    input  pre_t              in_pre,
    output logic              out_vld,
    output logic [ROOTW-1:0]  out_root,
    output pre_t              out_pre
);

    logic              cur_vld [ROOTW];
    logic [RADW-1:0]   cur_rad [ROOTW];
    logic [REMW-1:0]   cur_rem [ROOTW];
    logic [ROOTW-1:0]  cur_root [ROOTW];
    pre_t              cur_pre [ROOTW];

    logic              vld_reg [ROOTW];
    logic [RADW-1:0]   rad_reg [ROOTW];
    logic [REMW-1:0]   rem_reg [ROOTW];
    logic [ROOTW-1:0]  root_reg [ROOTW];
    pre_t              pre_reg [ROOTW];

    logic [REMW-1:0]   rem_next [ROOTW];
    logic [ROOTW-1:0]  root_next [ROOTW];

    for (genvar k = 0; k < ROOTW; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            assign cur_vld[k]  = in_vld;
            assign cur_rad[k]  = in_rad;
            assign cur_rem[k]  = '0;
            assign cur_root[k] = '0;
            assign cur_pre[k]  = in_pre;
        end
        else
        begin : g_rest
            assign cur_vld[k]  = vld_reg[k-1];
            assign cur_rad[k]  = rad_reg[k-1];
            assign cur_rem[k]  = rem_reg[k-1];
            assign cur_root[k] = root_reg[k-1];
            assign cur_pre[k]  = pre_reg[k-1];
        end

        always_comb
        begin
            logic [REMW-1:0] rem_sh;
            logic [REMW-1:0] trial;
            rem_sh = {cur_rem[k][REMW-3:0], cur_rad[k][RADW-1 -: 2]};
            trial  = {{(REMW-ROOTW-2){1'b0}}, cur_root[k], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next[k]  = rem_sh - trial;
                root_next[k] = {cur_root[k][ROOTW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh;
                root_next[k] = {cur_root[k][ROOTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= cur_vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {cur_rad[k][RADW-3:0], 2'b00};
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                pre_reg[k]  <= cur_pre[k];
            end
        end
    end

    assign out_vld  = vld_reg[ROOTW-1];
    assign out_root = root_reg[ROOTW-1];
    assign out_pre  = pre_reg[ROOTW-1];

endmodule

// ----- design/v4a_div.sv -----
// Pipelined four-lane restoring divider, one quotient bit per register stage.
// All lanes share one divisor. Depends on v4a_pkg.
module v4a_div import v4a_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [3:0][NUMW-1:0]  in_num,
    input  logic [DENW-1:0]       in_den,
    input  res_t                  in_res,
    output logic                  out_vld,
    output logic [3:0][NUMW-1:0]  out_quo,
    output res_t                  out_res
);

    logic                  cur_vld [NUMW];
    logic [3:0][NUMW-1:0]  cur_num [NUMW];
    logic [3:0][DENW-1:0]  cur_rem [NUMW];
    logic [DENW-1:0]       cur_den [NUMW];
    res_t                  cur_res [NUMW];

    logic                  vld_reg [NUMW];
    logic [3:0][NUMW-1:0]  num_reg [NUMW];
    logic [3:0][DENW-1:0]  rem_reg [NUMW];
    logic [DENW-1:0]       den_reg [NUMW];
    res_t                  res_reg [NUMW];

    logic [3:0][NUMW-1:0]  num_next [NUMW];
    logic [3:0][DENW-1:0]  rem_next [NUMW];

    for (genvar k = 0; k < NUMW; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            assign cur_vld[k] = in_vld;
            assign cur_num[k] = in_num;
            assign cur_rem[k] = '0;
            assign cur_den[k] = in_den;
            assign cur_res[k] = in_res;
        end
        else
        begin : g_rest
            assign cur_vld[k] = vld_reg[k-1];
            assign cur_num[k] = num_reg[k-1];
            assign cur_rem[k] = rem_reg[k-1];
            assign cur_den[k] = den_reg[k-1];
            assign cur_res[k] = res_reg[k-1];
        end

        // The dividend shifts out at the top while quotient bits shift in below.
        always_comb
        begin
            logic [DENW:0] rsh;
            logic [DENW:0] diff;
            logic          ge;
            for (int l = 0; l < 4; l++)
            begin
                rsh  = {cur_rem[k][l], cur_num[k][l][NUMW-1]};
                diff = rsh - {1'b0, cur_den[k]};
                ge   = (rsh >= {1'b0, cur_den[k]});
                rem_next[k][l] = ge ? diff[DENW-1:0] : rsh[DENW-1:0];
                num_next[k][l] = {cur_num[k][l][NUMW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= cur_vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k] <= num_next[k];
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= cur_den[k];
                res_reg[k] <= cur_res[k];
            end
        end
    end

    assign out_vld = vld_reg[NUMW-1];
    assign out_quo = num_reg[NUMW-1];
    assign out_res = res_reg[NUMW-1];

endmodule

// ----- design/vec4_arithmetic_unit.sv -----
// Four-component Q16.16 vector unit: a fully pipelined datapath.
// From input transfer to result an item passes 5 front stages, 33 square-root
// stages, 48 divider stages and the output register, the same for every operation.
// Throughput is one item per cycle; the whole pipeline holds when a result waits.
// Reset (rst_n, asynchronous, active low) clears only the valid bits.
// Depends on v4a_pkg, v4a_front, v4a_sqrt and v4a_div.
module vec4_arithmetic_unit import v4a_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  in_t   item,
    output logic  result_valid,
    input  logic  result_ready,
    output out_t  result
);

    // The pipeline moves as one. It advances whenever the output register is
    // empty or its result is taken in this cycle, so an item can enter on every
    // cycle in which results keep draining. Valid bits move with the data, so
    // bubbles pass through harmlessly.
    logic                  adv;

    logic                  fr_vld;
    pre_t                  fr_pre;
    logic [RADW-1:0]       fr_rad;

    logic                  sq_vld;
    logic [ROOTW-1:0]      sq_root;
    pre_t                  sq_pre;

    res_t                  dv_res_in;
    logic [DENW-1:0]       dv_den;

    logic                  dv_vld;
    logic [3:0][NUMW-1:0]  dv_quo;
    res_t                  dv_res;

    out_t                  result_next, result_reg;
    logic                  result_valid_reg;

    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    v4a_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (item_valid),
        .in_item (item),
        .out_vld (fr_vld),
        .out_pre (fr_pre),
        .out_rad (fr_rad)
    );

    // The square root runs for every item on the exact sum of the first four
    // products, the sum of squares for magnitude and normalize, which alone use it.
    v4a_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (fr_vld),
        .in_rad   (fr_rad),
        .in_pre   (fr_pre),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_pre  (sq_pre)
    );

    // Divider setup. Normalize divides by the unsaturated root, divide by the
    // magnitude of the scalar. A zero divisor on either raises the error flag,
    // and the final stage then leaves the vector at zero.
    always_comb
    begin
        dv_res_in = sq_pre.res;
        dv_den    = (sq_pre.res.op == OP_NORM) ? sq_root : sq_pre.res.den;
        dv_res_in.err = (dv_den == '0)
            && ((sq_pre.res.op == OP_DIV) || (sq_pre.res.op == OP_NORM));
        if (sq_pre.res.op == OP_MAG)
        begin
            dv_res_in.sc = sat_fn($signed({{(SUMW-ROOTW){1'b0}}, sq_root}));
        end
    end

    v4a_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (sq_vld),
        .in_num  (sq_pre.num),
        .in_den  (dv_den),
        .in_res  (dv_res_in),
        .out_vld (dv_vld),
        .out_quo (dv_quo),
        .out_res (dv_res)
    );

    // Apply the quotient sign and saturate. The quotient was formed on
    // magnitudes, which gives the truncation toward zero of signed division.
    always_comb
    begin
        logic signed [SUMW-1:0] qe;
        logic [3:0][DW-1:0]     rv;
        logic                   use_q;
        use_q = ((dv_res.op == OP_DIV) || (dv_res.op == OP_NORM)) && !dv_res.err;
        for (int l = 0; l < 4; l++)
        begin
            qe = $signed({{(SUMW-NUMW){1'b0}}, dv_quo[l]});
            if (dv_res.neg[l])
            begin
                qe = -qe;
            end
            rv[l] = use_q ? sat_fn(qe) : dv_res.r[l];
        end
        result_next.r_x        = $signed(rv[0]);
        result_next.r_y        = $signed(rv[1]);
        result_next.r_z        = $signed(rv[2]);
        result_next.r_w        = $signed(rv[3]);
        result_next.scalar_out = $signed(dv_res.sc);
        result_next.error_flag = dv_res.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
